// File: sv/pl0ts_pkg.sv
// shared types, codes and keyword tables of the pl0 token scanner
package pl0ts_pkg;

   // defaults for the top-level parameters
   localparam int MAX_TOKEN_LEN_DEF = 255;
   localparam int COUNTER_WIDTH_DEF = 32;

   // fixed sizes
   localparam int KEYWORD_COUNT = 14;
   localparam int KW_MAX_LEN    = 9;
   localparam int TAB_W         = 4;
   localparam logic [TAB_W-1:0] TAB_RESET = 4'd4;

   // scanner modes
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_BADID,
      MODE_LT,
      MODE_GT,
      MODE_COLON
   } scan_mode_type;

   // token classes
   localparam logic [3:0] CLS_RESERVED = 4'd0;
   localparam logic [3:0] CLS_IDENT    = 4'd1;
   localparam logic [3:0] CLS_INTEGER  = 4'd2;
   localparam logic [3:0] CLS_COMPARE  = 4'd3;
   localparam logic [3:0] CLS_ASSIGN   = 4'd4;
   localparam logic [3:0] CLS_ARITH    = 4'd5;
   localparam logic [3:0] CLS_END      = 4'd6;
   localparam logic [3:0] CLS_SEP      = 4'd7;
   localparam logic [3:0] CLS_UNKNOWN  = 4'd8;

   // operator codes
   localparam logic [3:0] OP_EQ     = 4'd0;
   localparam logic [3:0] OP_NE     = 4'd1;
   localparam logic [3:0] OP_LE     = 4'd2;
   localparam logic [3:0] OP_LT     = 4'd3;
   localparam logic [3:0] OP_GE     = 4'd4;
   localparam logic [3:0] OP_GT     = 4'd5;
   localparam logic [3:0] OP_ASSIGN = 4'd6;
   localparam logic [3:0] OP_ADD    = 4'd7;
   localparam logic [3:0] OP_SUB    = 4'd8;
   localparam logic [3:0] OP_MUL    = 4'd9;
   localparam logic [3:0] OP_DIV    = 4'd10;
   localparam logic [3:0] OP_SEMI   = 4'd11;
   localparam logic [3:0] OP_LPAREN = 4'd12;
   localparam logic [3:0] OP_RPAREN = 4'd13;
   localparam logic [3:0] OP_COMMA  = 4'd14;
   localparam logic [3:0] OP_NONE   = 4'd15;

   localparam logic [3:0] KW_NONE = 4'd14;

   // error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_BAD_ID    = 2'd1;
   localparam logic [1:0] ERR_NO_EQUALS = 2'd2;

   // one result item
   typedef struct packed {
      logic [3:0]  token_class;
      logic [3:0]  op_code;
      logic [3:0]  keyword_index;
      logic [7:0]  token_length;
      logic [31:0] line_number;
      logic [31:0] column_number;
      logic [1:0]  error_code;
      logic [7:0]  raw_char;
      logic        last;
   } token_type;

   // keyword lengths
   function automatic logic [3:0] kw_len(input int k);
      logic [3:0] n;
      unique case (k)
         0:       n = 4'd7;
         1:       n = 4'd5;
         2:       n = 4'd3;
         3:       n = 4'd9;
         4:       n = 4'd5;
         5:       n = 4'd2;
         6:       n = 4'd3;
         7:       n = 4'd5;
         8:       n = 4'd4;
         9:       n = 4'd4;
         10:      n = 4'd5;
         11:      n = 4'd4;
         12:      n = 4'd3;
         default: n = 4'd2;
      endcase
      return n;
   endfunction

   // keyword character at a position, zero past the end
   function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
      logic [71:0] w;
      int          idx;
      unique case (k)
         0:       w = {"program", 16'h0};
         1:       w = {"const", 32'h0};
         2:       w = {"var", 48'h0};
         3:       w = "procedure";
         4:       w = {"begin", 32'h0};
         5:       w = {"if", 56'h0};
         6:       w = {"end", 48'h0};
         7:       w = {"while", 32'h0};
         8:       w = {"call", 40'h0};
         9:       w = {"read", 40'h0};
         10:      w = {"write", 32'h0};
         11:      w = {"then", 40'h0};
         12:      w = {"odd", 48'h0};
         default: w = {"do", 56'h0};
      endcase
      idx = KW_MAX_LEN - 1 - int'(pos);
      if (int'(pos) < KW_MAX_LEN)
         return w[8*idx +: 8];
      else
         return 8'h00;
   endfunction

endpackage

// File: sv/pl0ts_req_if.sv
// source byte channel of the pl0 token scanner
interface pl0ts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_input;

   modport source (output valid, output ch, output end_of_input, input ready);
   modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

// File: sv/pl0ts_rsp_if.sv
// token result channel of the pl0 token scanner
interface pl0ts_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_class;
   logic [3:0]  op_code;
   logic [3:0]  keyword_index;
   logic [7:0]  token_length;
   logic [31:0] line_number;
   logic [31:0] column_number;
   logic [1:0]  error_code;
   logic [7:0]  raw_char;
   logic        last;

   modport source (output valid, output token_class, output op_code, output keyword_index,
                   output token_length, output line_number, output column_number,
                   output error_code, output raw_char, output last, input ready);
   modport sink (input valid, input token_class, input op_code, input keyword_index,
                 input token_length, input line_number, input column_number,
                 input error_code, input raw_char, input last, output ready);
endinterface

// File: sv/pl0_token_scanner.sv
// pl0 token scanner: one source byte per transfer in, classified tokens out
//
// Source bytes arrive on req (ch, end_of_input); tokens leave on rsp with
// class, operator, keyword index, length, line, column, error and raw byte.
// A byte may cause up to two tokens; last marks the final one of a byte.
// A byte is scanned in the cycle of its transfer and its tokens sit in a
// two-entry result register from the next cycle on. Throughput is one byte
// per cycle while each byte gives at most one token and rsp is taken every
// cycle; a byte that gives two tokens holds off the next byte until the
// result register has drained. Keyword matching is a 14-bit match vector
// narrowed on every letter. The user must write tab_width via csr_we and
// csr_wdata only while no byte is in flight; the block does not enforce
// it. Reset (synchronous) returns to idle, line 1, column 1, tab width 4
// and empties the result register. When rsp stalls, tokens are held and req
// drops ready once the result register cannot take a full byte's output.
module pl0_token_scanner
   import pl0ts_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   pl0ts_req_if.sink        req,
   pl0ts_rsp_if.source      rsp,
   input  logic             csr_we,
   input  logic [TAB_W-1:0] csr_wdata
);

   localparam int RUN_W = $clog2(MAX_TOKEN_LEN + 1);
   localparam int CW    = COUNTER_WIDTH;
   localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   // state
   scan_mode_type              mode_ff;
   logic [KEYWORD_COUNT-1:0]   alive_ff;
   logic [RUN_W-1:0]           run_ff;
   logic [CW-1:0]              line_ff;
   logic [CW-1:0]              col_ff;
   logic [TAB_W-1:0]           tab_ff;

   // result register
   token_type                  q0_ff, q1_ff, q0_in, q1_in;
   logic [1:0]                 cnt_ff, cnt_in;

   // next-state signals
   scan_mode_type              mode_mid, mode_in;
   logic [KEYWORD_COUNT-1:0]   alive_mid, base_alive, keep;
   logic [RUN_W-1:0]           run_mid, base_run;
   logic [CW-1:0]              line_next, col_next, col_addend;
   logic [CW:0]                col_sum, line_sum;
   logic                       done, feed, match, crlf, is_let, is_dig;
   logic [7:0]                 c;
   logic                       accept, pop;

   // token candidates
   token_type                  t_first, t_fresh, t_eoi, t_a, t_b;
   logic                       v_first, v_fresh, v_eoi;
   logic [1:0]                 n_tok;

   // build one token
   function automatic token_type mk_tok(input logic [3:0] cls, input logic [3:0] op,
                                        input logic [3:0] kw, input logic [7:0] len,
                                        input logic [1:0] err, input logic [7:0] raw,
                                        input logic [CW-1:0] ln, input logic [CW-1:0] cl);
      token_type t;
      logic [63:0] lw, cw;
      lw = 64'(ln);
      cw = 64'(cl);
      t.token_class   = cls;
      t.op_code       = op;
      t.keyword_index = kw;
      t.token_length  = len;
      t.line_number   = lw[31:0];
      t.column_number = cw[31:0];
      t.error_code    = err;
      t.raw_char      = raw;
      t.last          = 1'b0;
      return t;
   endfunction

   // token for a pending run or operator
   function automatic token_type flush_tok(input scan_mode_type m,
                                           input logic [KEYWORD_COUNT-1:0] alive,
                                           input logic [RUN_W-1:0] run,
                                           input logic [CW-1:0] ln,
                                           input logic [CW-1:0] cl);
      token_type t;
      logic [3:0]  kw;
      logic [16:0] r;
      logic [7:0]  len;
      kw  = KW_NONE;
      r   = 17'(run);
      len = (r > 17'd255) ? 8'hFF : r[7:0];
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
         if (alive[k] && (r == 17'(kw_len(k))))
            kw = 4'(k);
      end
      unique case (m)
         MODE_IDENT: begin
            t = mk_tok((kw != KW_NONE) ? CLS_RESERVED : CLS_IDENT, OP_NONE, kw, len,
                       ERR_NONE, 8'h00, ln, cl);
         end
         MODE_NUMBER: t = mk_tok(CLS_INTEGER, OP_NONE, KW_NONE, len, ERR_NONE, 8'h00, ln, cl);
         MODE_BADID:  t = mk_tok(CLS_IDENT, OP_NONE, KW_NONE, len, ERR_BAD_ID, 8'h00, ln, cl);
         MODE_LT:     t = mk_tok(CLS_COMPARE, OP_LT, KW_NONE, 8'd1, ERR_NONE, "<", ln, cl);
         MODE_GT:     t = mk_tok(CLS_COMPARE, OP_GT, KW_NONE, 8'd1, ERR_NONE, ">", ln, cl);
         MODE_COLON: begin
            t = mk_tok(CLS_ASSIGN, OP_ASSIGN, KW_NONE, 8'd1, ERR_NO_EQUALS, ":", ln, cl);
         end
         default:     t = mk_tok(CLS_UNKNOWN, OP_NONE, KW_NONE, 8'd0, ERR_NONE, 8'h00, ln, cl);
      endcase
      return t;
   endfunction

   assign c      = req.ch;
   assign is_let = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   assign is_dig = (c >= "0") && (c <= "9");
   assign crlf   = (c == 8'h0D) || (c == 8'h0A);

   // handshake
   assign req.ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp.ready);
   assign accept    = req.valid && req.ready;
   assign pop       = rsp.valid && rsp.ready;

   // next state: mode, match vector, run length, counters
   always_comb begin
      unique case (mode_ff)
         MODE_IDENT, MODE_BADID, MODE_NUMBER: done = is_let || is_dig;
         MODE_LT:                             done = (c == ">") || (c == "=");
         MODE_GT, MODE_COLON:                 done = (c == "=");
         default:                             done = 1'b0;
      endcase

      feed = done ? ((mode_ff == MODE_IDENT) || (mode_ff == MODE_BADID) ||
                     (mode_ff == MODE_NUMBER))
                  : (is_let || is_dig);
      match      = done ? (mode_ff == MODE_IDENT) : is_let;
      base_alive = done ? alive_ff : {KEYWORD_COUNT{1'b1}};
      base_run   = done ? run_ff : '0;

      // narrow the keyword match vector by this character
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
         keep[k] = match && (32'(base_run) < 32'(kw_len(k))) &&
                   (kw_char(k, base_run[3:0]) == c);
      end

      if (feed) begin
         alive_mid = base_alive & keep;
         run_mid   = (32'(base_run) < MAX_TOKEN_LEN) ? base_run + RUN_W'(1) : base_run;
      end else begin
         alive_mid = alive_ff;
         run_mid   = run_ff;
      end

      if (done) begin
         unique case (mode_ff)
            MODE_IDENT:  mode_mid = MODE_IDENT;
            MODE_BADID:  mode_mid = MODE_BADID;
            MODE_NUMBER: mode_mid = is_let ? MODE_BADID : MODE_NUMBER;
            default:     mode_mid = MODE_IDLE;
         endcase
      end else begin
         priority if (is_let)   mode_mid = MODE_IDENT;
         else if (is_dig)       mode_mid = MODE_NUMBER;
         else if (c == "<")     mode_mid = MODE_LT;
         else if (c == ">")     mode_mid = MODE_GT;
         else if (c == ":")     mode_mid = MODE_COLON;
         else                   mode_mid = MODE_IDLE;
      end
      mode_in = req.end_of_input ? MODE_IDLE : mode_mid;

      // saturating column and line counters
      col_addend = (!done && (c == 8'h09)) ? CW'(tab_ff) : CNT_ONE;
      col_sum    = {1'b0, col_ff} + {1'b0, col_addend};
      line_sum   = {1'b0, line_ff} + {1'b0, CNT_ONE};
      if (!done && crlf) begin
         col_next  = CNT_ONE;
         line_next = line_sum[CW] ? CNT_MAX : line_sum[CW-1:0];
      end else begin
         col_next  = col_sum[CW] ? CNT_MAX : col_sum[CW-1:0];
         line_next = line_ff;
      end
   end

   // outputs: candidate tokens in emission order
   always_comb begin
      // pending token, or a finished two-character operator
      if (done) begin
         v_first = (mode_ff == MODE_LT) || (mode_ff == MODE_GT) || (mode_ff == MODE_COLON);
         unique case (mode_ff)
            MODE_LT: begin
               t_first = mk_tok(CLS_COMPARE, (c == ">") ? OP_NE : OP_LE, KW_NONE, 8'd2,
                                ERR_NONE, 8'h00, line_ff, col_next);
            end
            MODE_GT: begin
               t_first = mk_tok(CLS_COMPARE, OP_GE, KW_NONE, 8'd2, ERR_NONE, 8'h00,
                                line_ff, col_next);
            end
            default: begin
               t_first = mk_tok(CLS_ASSIGN, OP_ASSIGN, KW_NONE, 8'd2, ERR_NONE, 8'h00,
                                line_ff, col_next);
            end
         endcase
      end else begin
         v_first = (mode_ff != MODE_IDLE);
         t_first = flush_tok(mode_ff, alive_ff, run_ff, line_ff, col_ff);
      end

      // single-character tokens from idle
      v_fresh = !done && !is_let && !is_dig && !crlf && (c != " ") && (c != 8'h09) &&
                (c != "<") && (c != ">") && (c != ":");
      unique case (c)
         "=": t_fresh = mk_tok(CLS_COMPARE, OP_EQ, KW_NONE, 8'd1, ERR_NONE, c,
                               line_next, col_next);
         "+": t_fresh = mk_tok(CLS_ARITH, OP_ADD, KW_NONE, 8'd1, ERR_NONE, c,
                               line_next, col_next);
         "-": t_fresh = mk_tok(CLS_ARITH, OP_SUB, KW_NONE, 8'd1, ERR_NONE, c,
                               line_next, col_next);
         "*": t_fresh = mk_tok(CLS_ARITH, OP_MUL, KW_NONE, 8'd1, ERR_NONE, c,
                               line_next, col_next);
         "/": t_fresh = mk_tok(CLS_ARITH, OP_DIV, KW_NONE, 8'd1, ERR_NONE, c,
                               line_next, col_next);
         ";": t_fresh = mk_tok(CLS_END, OP_SEMI, KW_NONE, 8'd1, ERR_NONE, c,
                               line_next, col_next);
         "(": t_fresh = mk_tok(CLS_SEP, OP_LPAREN, KW_NONE, 8'd1, ERR_NONE, c,
                               line_next, col_next);
         ")": t_fresh = mk_tok(CLS_SEP, OP_RPAREN, KW_NONE, 8'd1, ERR_NONE, c,
                               line_next, col_next);
         ",": t_fresh = mk_tok(CLS_SEP, OP_COMMA, KW_NONE, 8'd1, ERR_NONE, c,
                               line_next, col_next);
         default: t_fresh = mk_tok(CLS_UNKNOWN, OP_NONE, KW_NONE, 8'd1, ERR_NONE, c,
                                   line_next, col_next);
      endcase

      // flush at end of input
      v_eoi = req.end_of_input && (mode_mid != MODE_IDLE);
      t_eoi = flush_tok(mode_mid, alive_mid, run_mid, line_next, col_next);

      // pack the valid candidates into two slots
      t_a   = t_first;
      t_b   = t_fresh;
      n_tok = 2'd0;
      priority if (v_first && v_fresh) begin
         t_a = t_first; t_b = t_fresh; n_tok = 2'd2;
      end else if (v_first && v_eoi) begin
         t_a = t_first; t_b = t_eoi; n_tok = 2'd2;
      end else if (v_fresh) begin
         t_a = t_fresh; n_tok = 2'd1;
      end else if (v_first) begin
         t_a = t_first; n_tok = 2'd1;
      end else if (v_eoi) begin
         t_a = t_eoi; n_tok = 2'd1;
      end else begin
         n_tok = 2'd0;
      end
      t_a.last = (n_tok == 2'd1);
      t_b.last = 1'b1;
   end

   // result register load and drain
   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         q0_in  = t_a;
         q1_in  = t_b;
         cnt_in = n_tok;
      end else if (pop) begin
         q0_in  = q1_ff;
         cnt_in = cnt_ff - 2'd1;
      end
   end

   // control and scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         alive_ff <= {KEYWORD_COUNT{1'b1}};
         run_ff   <= '0;
         line_ff  <= CNT_ONE;
         col_ff   <= CNT_ONE;
         tab_ff   <= TAB_RESET;
         cnt_ff   <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (csr_we)
            tab_ff <= csr_wdata;
         if (accept) begin
            mode_ff  <= mode_in;
            alive_ff <= alive_mid;
            run_ff   <= run_mid;
            line_ff  <= line_next;
            col_ff   <= col_next;
         end
      end
   end

   // token payload
   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign rsp.valid         = (cnt_ff != 2'd0);
   assign rsp.token_class   = q0_ff.token_class;
   assign rsp.op_code       = q0_ff.op_code;
   assign rsp.keyword_index = q0_ff.keyword_index;
   assign rsp.token_length  = q0_ff.token_length;
   assign rsp.line_number   = q0_ff.line_number;
   assign rsp.column_number = q0_ff.column_number;
   assign rsp.error_code    = q0_ff.error_code;
   assign rsp.raw_char      = q0_ff.raw_char;
   assign rsp.last          = q0_ff.last;

endmodule
